// ===== rtl/vpd_pkg.sv =====
// Shared types, pipeline depths and IEEE single helper functions for the
// vertex projection pipeline. No dependencies.
`default_nettype none

package vpd_pkg;

   typedef logic [31:0]        fp_type;
   typedef logic signed [9:0]  exp_type;

   // per-item side data that rides along the divider stages
   typedef struct packed {
      logic   sign;
      logic   spec;
      fp_type spec_word;
      logic   wz;
   } div_side_type;

   localparam fp_type  CanonNan = 32'h7FC0_0000;
   localparam fp_type  PosZero  = 32'h0000_0000;
   localparam fp_type  NegZero  = 32'h8000_0000;
   localparam exp_type ExpBias  = 10'sd127;
   localparam exp_type ExpMaxN  = 10'sd254;

   localparam int unsigned Rows      = 4;
   localparam int unsigned Cols      = 4;
   localparam int unsigned MulLat    = 3;
   localparam int unsigned AddLat    = 3;
   localparam int unsigned DivSteps  = 4;
   localparam int unsigned DivStages = 7;
   localparam int unsigned DivLat    = DivStages + 2;
   localparam int unsigned PipeLat   = MulLat + 3 * AddLat + DivLat;

   function automatic logic is_nan(input fp_type a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(input fp_type a);
      return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
   endfunction

   function automatic logic is_zero(input fp_type a);
      return a[30:0] == 31'd0;
   endfunction

   function automatic fp_type canon(input fp_type a);
      return is_nan(a) ? CanonNan : a;
   endfunction

   // significand with hidden bit
   function automatic logic [23:0] mant(input fp_type a);
      return {|a[30:23], a[22:0]};
   endfunction

   // biased exponent, subnormals read as 1
   function automatic exp_type expo(input fp_type a);
      return (a[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, a[30:23]});
   endfunction

   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] n;
      logic       found;
      n     = '0;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
         if (!found) begin
            if (v[i]) found = 1'b1;
            else      n = n + 5'd1;
         end
      end
      return n;
   endfunction

   // s[26] is the unit bit, s[2] guard, s[1] round, s[0] sticky; RNE
   function automatic fp_type round_pack(input logic sign, input exp_type e,
                                         input logic [26:0] s);
      logic [53:0] ext;
      logic [26:0] s2;
      logic        sub;
      logic [9:0]  sh;
      logic        inc;
      logic [24:0] m;
      exp_type     ef;
      fp_type      r;
      sub = (e < 10'sd1);
      sh  = 10'(10'sd1 - e);
      ext = '0;
      if (!sub) begin
         s2 = s;
      end else if (sh > 10'd27) begin
         s2 = {26'd0, |s};
      end else begin
         ext = {s, 27'd0} >> sh;
         s2  = {ext[53:28], |ext[27:0]};
      end
      inc = s2[2] & (s2[1] | s2[0] | s2[3]);
      m   = {1'b0, s2[26:3]} + {24'd0, inc};
      ef  = e + $signed({9'd0, m[24]});
      if (sub)                 r = {sign, 7'd0, m[23], m[22:0]};
      else if (ef > ExpMaxN)   r = {sign, 8'hFF, 23'd0};
      else                     r = {sign, ef[7:0], m[22:0]};
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/vpd_fmul.sv =====
// IEEE single multiplier, three stages: operand normalize, 24x24 product,
// normalize and round. Uses vpd_pkg.
`default_nettype none

module vpd_fmul (
   input  wire logic            clock,
   input  wire logic            en,
   input  wire vpd_pkg::fp_type a,
   input  wire vpd_pkg::fp_type b,
   output vpd_pkg::fp_type      y
);

   logic [4:0]       lza, lzb;
   logic [23:0]      ma_in, mb_in, ma_ff, mb_ff;
   vpd_pkg::exp_type ea_in, eb_in, ea_ff, eb_ff;
   logic             sign_in, nan_in, inf_in, zero_in;
   logic             sign_ff, nan_ff, inf_ff, zero_ff;

   logic [47:0]      prod_in, prod_ff;
   vpd_pkg::exp_type ep_in, ep_ff;
   logic             sign2_ff, nan2_ff, inf2_ff, zero2_ff;

   logic [26:0]      sig;
   vpd_pkg::exp_type er;
   vpd_pkg::fp_type  y_in, y_ff;

   // stage 1: unpack, pull subnormals up to a leading one
   always_comb begin
      lza     = vpd_pkg::lzc27({vpd_pkg::mant(a), 3'b000});
      lzb     = vpd_pkg::lzc27({vpd_pkg::mant(b), 3'b000});
      ma_in   = 24'(vpd_pkg::mant(a) << lza);
      mb_in   = 24'(vpd_pkg::mant(b) << lzb);
      ea_in   = vpd_pkg::expo(a) - $signed({5'd0, lza});
      eb_in   = vpd_pkg::expo(b) - $signed({5'd0, lzb});
      sign_in = a[31] ^ b[31];
      nan_in  = vpd_pkg::is_nan(a) | vpd_pkg::is_nan(b)
              | (vpd_pkg::is_inf(a) & vpd_pkg::is_zero(b))
              | (vpd_pkg::is_zero(a) & vpd_pkg::is_inf(b));
      inf_in  = vpd_pkg::is_inf(a) | vpd_pkg::is_inf(b);
      zero_in = vpd_pkg::is_zero(a) | vpd_pkg::is_zero(b);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff   <= ma_in;
         mb_ff   <= mb_in;
         ea_ff   <= ea_in;
         eb_ff   <= eb_in;
         sign_ff <= sign_in;
         nan_ff  <= nan_in;
         inf_ff  <= inf_in;
         zero_ff <= zero_in;
      end
   end

   // stage 2: significand product
   assign prod_in = ma_ff * mb_ff;
   assign ep_in   = ea_ff + eb_ff - vpd_pkg::ExpBias;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         ep_ff    <= ep_in;
         sign2_ff <= sign_ff;
         nan2_ff  <= nan_ff;
         inf2_ff  <= inf_ff;
         zero2_ff <= zero_ff;
      end
   end

   // stage 3: product is in [1,4)
   always_comb begin
      if (prod_ff[47]) begin
         sig = {prod_ff[47:22], |prod_ff[21:0]};
         er  = ep_ff + 10'sd1;
      end else begin
         sig = {prod_ff[46:21], |prod_ff[20:0]};
         er  = ep_ff;
      end
      if (nan2_ff)       y_in = vpd_pkg::CanonNan;
      else if (inf2_ff)  y_in = {sign2_ff, 8'hFF, 23'd0};
      else if (zero2_ff) y_in = {sign2_ff, 31'd0};
      else               y_in = vpd_pkg::round_pack(sign2_ff, er, sig);
   end

   always_ff @(posedge clock) begin
      if (en) y_ff <= y_in;
   end

   assign y = y_ff;

endmodule

`default_nettype wire

// ===== rtl/vpd_fadd.sv =====
// IEEE single adder, three stages: align, add with leading-zero count,
// normalize and round. Uses vpd_pkg.
`default_nettype none

module vpd_fadd (
   input  wire logic            clock,
   input  wire logic            en,
   input  wire vpd_pkg::fp_type a,
   input  wire vpd_pkg::fp_type b,
   output vpd_pkg::fp_type      y
);

   logic             swap;
   vpd_pkg::fp_type  big, sml;
   vpd_pkg::exp_type diff;
   logic [26:0]      msml;
   logic [53:0]      ext;
   logic [26:0]      al_in, al_ff, mb_ff;
   vpd_pkg::exp_type e_ff, e2_ff;
   logic             sub_ff, sign_ff, nan_ff, inf_ff, isgn_ff, zsgn_ff;
   logic             nan_in, inf_in;

   logic [27:0]      sum_in, sum_ff;
   logic [4:0]       lz_ff;
   logic             sign2_ff, nan2_ff, inf2_ff, isgn2_ff, zsgn2_ff;

   logic [26:0]      sig;
   vpd_pkg::exp_type er;
   vpd_pkg::fp_type  y_in, y_ff;

   // stage 1: order by magnitude, shift the smaller with sticky
   always_comb begin
      swap = b[30:0] > a[30:0];
      big  = swap ? b : a;
      sml  = swap ? a : b;
      diff = vpd_pkg::expo(big) - vpd_pkg::expo(sml);
      msml = {vpd_pkg::mant(sml), 3'b000};
      ext  = {msml, 27'd0} >> $unsigned(diff);
      if (diff > 10'sd27) al_in = {26'd0, |msml};
      else                al_in = {ext[53:28], |ext[27:0]};
      nan_in = vpd_pkg::is_nan(a) | vpd_pkg::is_nan(b)
             | (vpd_pkg::is_inf(a) & vpd_pkg::is_inf(b) & (a[31] != b[31]));
      inf_in = vpd_pkg::is_inf(a) | vpd_pkg::is_inf(b);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         al_ff   <= al_in;
         mb_ff   <= {vpd_pkg::mant(big), 3'b000};
         e_ff    <= vpd_pkg::expo(big);
         sub_ff  <= a[31] ^ b[31];
         sign_ff <= big[31];
         nan_ff  <= nan_in;
         inf_ff  <= inf_in;
         isgn_ff <= vpd_pkg::is_inf(a) ? a[31] : b[31];
         zsgn_ff <= a[31] & b[31];
      end
   end

   // stage 2: magnitude add or subtract
   always_comb begin
      if (sub_ff) sum_in = {1'b0, mb_ff} - {1'b0, al_ff};
      else        sum_in = {1'b0, mb_ff} + {1'b0, al_ff};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff   <= sum_in;
         lz_ff    <= vpd_pkg::lzc27(sum_in[26:0]);
         e2_ff    <= e_ff;
         sign2_ff <= sign_ff;
         nan2_ff  <= nan_ff;
         inf2_ff  <= inf_ff;
         isgn2_ff <= isgn_ff;
         zsgn2_ff <= zsgn_ff;
      end
   end

   // stage 3: normalize, round, specials
   always_comb begin
      if (sum_ff[27]) begin
         sig = {sum_ff[27:2], sum_ff[1] | sum_ff[0]};
         er  = e2_ff + 10'sd1;
      end else begin
         sig = 27'(sum_ff[26:0] << lz_ff);
         er  = e2_ff - $signed({5'd0, lz_ff});
      end
      if (nan2_ff)              y_in = vpd_pkg::CanonNan;
      else if (inf2_ff)         y_in = {isgn2_ff, 8'hFF, 23'd0};
      else if (sum_ff == 28'd0) y_in = {zsgn2_ff, 31'd0};
      else                      y_in = vpd_pkg::round_pack(sign2_ff, er, sig);
   end

   always_ff @(posedge clock) begin
      if (en) y_ff <= y_in;
   end

   assign y = y_ff;

endmodule

`default_nettype wire

// ===== rtl/vpd_fdiv.sv =====
// IEEE single divider: operand normalize, restoring quotient stages of a few
// bits each, round. A zero divisor passes the numerator. Uses vpd_pkg.
`default_nettype none

module vpd_fdiv (
   input  wire logic            clock,
   input  wire logic            en,
   input  wire vpd_pkg::fp_type n,
   input  wire vpd_pkg::fp_type d,
   output vpd_pkg::fp_type      q,
   output logic                 wz
);

   localparam int unsigned QuotW = vpd_pkg::DivSteps * vpd_pkg::DivStages;

   logic [4:0]            lzn, lzd;
   logic [23:0]           mn_ff, md_ff;
   vpd_pkg::exp_type      e_in, e_ff;
   vpd_pkg::div_side_type side_in, side_ff;
   logic                  nan_c, inf_c, zero_c, sgn_c;

   logic [24:0]           rem_ff  [vpd_pkg::DivStages];
   logic [QuotW-1:0]      quo_ff  [vpd_pkg::DivStages];
   logic [23:0]           dv_ff   [vpd_pkg::DivStages];
   vpd_pkg::exp_type      ex_ff   [vpd_pkg::DivStages];
   vpd_pkg::div_side_type sd_ff   [vpd_pkg::DivStages];

   logic [26:0]           sig;
   vpd_pkg::fp_type       q_in, q_ff;
   logic                  wz_ff;

   // stage A: unpack and normalize both operands, settle special cases
   always_comb begin
      lzn    = vpd_pkg::lzc27({vpd_pkg::mant(n), 3'b000});
      lzd    = vpd_pkg::lzc27({vpd_pkg::mant(d), 3'b000});
      e_in   = (vpd_pkg::expo(n) - $signed({5'd0, lzn}))
             - (vpd_pkg::expo(d) - $signed({5'd0, lzd})) + vpd_pkg::ExpBias;
      sgn_c  = n[31] ^ d[31];
      nan_c  = vpd_pkg::is_nan(n) | vpd_pkg::is_nan(d)
             | (vpd_pkg::is_inf(n) & vpd_pkg::is_inf(d));
      inf_c  = vpd_pkg::is_inf(n);
      zero_c = vpd_pkg::is_zero(n) | vpd_pkg::is_inf(d);
      side_in.sign = sgn_c;
      side_in.wz   = vpd_pkg::is_zero(d);
      side_in.spec = side_in.wz | nan_c | inf_c | zero_c;
      if (side_in.wz)  side_in.spec_word = vpd_pkg::canon(n);
      else if (nan_c)  side_in.spec_word = vpd_pkg::CanonNan;
      else if (inf_c)  side_in.spec_word = {sgn_c, 8'hFF, 23'd0};
      else             side_in.spec_word = {sgn_c, 31'd0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mn_ff   <= 24'(vpd_pkg::mant(n) << lzn);
         md_ff   <= 24'(vpd_pkg::mant(d) << lzd);
         e_ff    <= e_in;
         side_ff <= side_in;
      end
   end

   // quotient stages, DivSteps restoring steps each
   for (genvar k = 0; k < vpd_pkg::DivStages; k++) begin : g_iter
      logic [24:0]           r0, r;
      logic [QuotW-1:0]      q0, qb;
      logic [23:0]           dv0;
      vpd_pkg::exp_type      e0;
      vpd_pkg::div_side_type s0;
      logic                  bt;

      if (k == 0) begin : g_first
         logic lt;
         // start with a partial remainder in [d, 2d)
         assign lt  = mn_ff < md_ff;
         assign r0  = lt ? {mn_ff, 1'b0} : {1'b0, mn_ff};
         assign e0  = e_ff - $signed({9'd0, lt});
         assign q0  = '0;
         assign dv0 = md_ff;
         assign s0  = side_ff;
      end else begin : g_next
         assign r0  = rem_ff[k-1];
         assign e0  = ex_ff[k-1];
         assign q0  = quo_ff[k-1];
         assign dv0 = dv_ff[k-1];
         assign s0  = sd_ff[k-1];
      end

      always_comb begin
         r  = r0;
         qb = q0;
         bt = 1'b0;
         for (int i = 0; i < vpd_pkg::DivSteps; i++) begin
            bt = r >= {1'b0, dv0};
            if (bt) r = r - {1'b0, dv0};
            r  = {r[23:0], 1'b0};
            qb = {qb[QuotW-2:0], bt};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= r;
            quo_ff[k] <= qb;
            dv_ff[k]  <= dv0;
            ex_ff[k]  <= e0;
            sd_ff[k]  <= s0;
         end
      end
   end

   // round stage
   always_comb begin
      sig = {quo_ff[vpd_pkg::DivStages-1][QuotW-1:QuotW-26],
             (|quo_ff[vpd_pkg::DivStages-1][QuotW-27:0])
             | (|rem_ff[vpd_pkg::DivStages-1])};
      if (sd_ff[vpd_pkg::DivStages-1].spec)
         q_in = sd_ff[vpd_pkg::DivStages-1].spec_word;
      else
         q_in = vpd_pkg::round_pack(sd_ff[vpd_pkg::DivStages-1].sign,
                                    ex_ff[vpd_pkg::DivStages-1], sig);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff  <= q_in;
         wz_ff <= sd_ff[vpd_pkg::DivStages-1].wz;
      end
   end

   assign q  = q_ff;
   assign wz = wz_ff;

endmodule

`default_nettype wire

// ===== rtl/vertex_projection_divide.sv =====
// Vertex projection top level: coefficient store, 4x4 multiply-accumulate
// and perspective divide. Uses vpd_pkg, vpd_fmul, vpd_fadd, vpd_fdiv.
//
// Usage:
//  - req channel: one transfer per item. req_tuser = 0 loads req_tdata's
//    coefficient into the matrix entry (row, col) at the transfer edge and
//    yields no result. req_tuser = 1 sends a vertex (x, y, z, 1), transformed
//    by the matrix as it stands at its transfer (later loads do not touch it).
//  - rsp channel: one transfer per vertex, in order: projected x, y, z in
//    rsp_tdata and the w-was-zero flag in rsp_tuser (x, y, z then undivided).
//  - Data path: multiply, then the accumulate adders, then divide, all
//    registered. Throughput: one item per cycle while rsp is not stalled,
//    set by the fully pipelined multiply, add and divide units.
//  - Stall: the whole pipe holds while a result waits on rsp_tready; empty
//    slots keep moving otherwise, so req_tready = !rsp_tvalid | rsp_tready.
//  - Reset: synchronous, clears all in-flight items and sets every matrix
//    coefficient to +0.0.
`default_nettype none

module vertex_projection_divide (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [1:0] coef_row, [3:2] coef_col, [35:4] coef_value, [67:36] vertex_x,
   // [99:68] vertex_y, [131:100] vertex_z, [135:132] zero
   input  wire logic [135:0] req_tdata,
   // [0] mode
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [31:0] proj_x, [63:32] proj_y, [95:64] proj_z
   output logic [95:0]       rsp_tdata,
   // [0] w_zero
   output logic              rsp_tuser
);

   localparam int unsigned Lat   = vpd_pkg::PipeLat;
   localparam int unsigned M3Lat = vpd_pkg::MulLat + 2 * vpd_pkg::AddLat;

   logic                       advance;
   logic                       accept;
   logic [Lat-1:0]             vld_ff, vld_in;
   vpd_pkg::fp_type            matrix_ff [vpd_pkg::Rows * vpd_pkg::Cols];
   vpd_pkg::fp_type            vtx [3];
   vpd_pkg::fp_type            col_sum [vpd_pkg::Cols];
   vpd_pkg::fp_type            proj [3];
   logic                       w_zero;

   // whole pipe moves unless the output register is full and not taken
   assign advance    = !vld_ff[Lat-1] || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && req_tready;

   assign vtx[0] = req_tdata[67:36];
   assign vtx[1] = req_tdata[99:68];
   assign vtx[2] = req_tdata[131:100];

   // coefficient store, written on a load transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < vpd_pkg::Rows * vpd_pkg::Cols; i++) begin
            matrix_ff[i] <= vpd_pkg::PosZero;
         end
      end else if (accept && !req_tuser) begin
         matrix_ff[{req_tdata[1:0], req_tdata[3:2]}] <= req_tdata[35:4];
      end
   end

   // valid bits travel alongside the datapath
   assign vld_in = {vld_ff[Lat-2:0], accept && req_tuser};

   always_ff @(posedge clock) begin
      if (reset)        vld_ff <= '0;
      else if (advance) vld_ff <= vld_in;
   end

   // one column per output coordinate: three products, then a row-ordered
   // accumulate; row 3 is multiplied by 1.0, so its coefficient goes in as is
   for (genvar j = 0; j < vpd_pkg::Cols; j++) begin : g_col
      vpd_pkg::fp_type prod [3];
      vpd_pkg::fp_type acc1, sum1, sum2;
      vpd_pkg::fp_type p2_dly_ff [vpd_pkg::AddLat];
      vpd_pkg::fp_type m3_dly_ff [M3Lat];

      for (genvar i = 0; i < 3; i++) begin : g_row
         vpd_fmul u_mul (
            .clock (clock),
            .en    (advance),
            .a     (vtx[i]),
            .b     (matrix_ff[i * vpd_pkg::Cols + j]),
            .y     (prod[i])
         );
      end

      // +0.0 + p0: only a negative zero changes
      assign acc1 = (prod[0] == vpd_pkg::NegZero) ? vpd_pkg::PosZero : prod[0];

      always_ff @(posedge clock) begin
         if (advance) begin
            p2_dly_ff[0] <= prod[2];
            for (int k = 1; k < vpd_pkg::AddLat; k++) begin
               p2_dly_ff[k] <= p2_dly_ff[k-1];
            end
            m3_dly_ff[0] <= matrix_ff[3 * vpd_pkg::Cols + j];
            for (int k = 1; k < M3Lat; k++) begin
               m3_dly_ff[k] <= m3_dly_ff[k-1];
            end
         end
      end

      vpd_fadd u_add1 (
         .clock (clock), .en (advance), .a (acc1), .b (prod[1]), .y (sum1)
      );
      vpd_fadd u_add2 (
         .clock (clock), .en (advance), .a (sum1),
         .b (p2_dly_ff[vpd_pkg::AddLat-1]), .y (sum2)
      );
      vpd_fadd u_add3 (
         .clock (clock), .en (advance), .a (sum2),
         .b (m3_dly_ff[M3Lat-1]), .y (col_sum[j])
      );
   end

   // perspective divide; the x lane also reports the zero-w flag
   vpd_fdiv u_div_x (
      .clock (clock), .en (advance), .n (col_sum[0]), .d (col_sum[3]),
      .q (proj[0]), .wz (w_zero)
   );
   vpd_fdiv u_div_y (
      .clock (clock), .en (advance), .n (col_sum[1]), .d (col_sum[3]),
      .q (proj[1]), .wz ()
   );
   vpd_fdiv u_div_z (
      .clock (clock), .en (advance), .n (col_sum[2]), .d (col_sum[3]),
      .q (proj[2]), .wz ()
   );

   // the divider's round stage is the output register
   assign rsp_tvalid = vld_ff[Lat-1];
   assign rsp_tdata  = {proj[2], proj[1], proj[0]};
   assign rsp_tuser  = w_zero;

endmodule

`default_nettype wire

// ===== rtl/vpd_checker.sv =====
// Port-level checks for vertex_projection_divide, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module vpd_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [95:0]  rsp_tdata,
   input wire logic         rsp_tuser
);

   // a result is never offered right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // a refused result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped without a transfer");

   // a refused result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // a stalled output stops intake; an empty or drained output allows it
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not follow the output stall");

endmodule

bind vertex_projection_divide vpd_checker u_vpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for vertex_projection_divide: directed table, then
// random coefficient loads and vertex transfers. Depends on vpd_pkg and the DUT.
`timescale 1ns / 1ps

module tb;

   typedef enum logic {LOAD_COEF = 1'b0, XFORM_VERTEX = 1'b1} op_type;

   typedef struct packed {
      op_type          mode;
      logic [1:0]      row;
      logic [1:0]      col;
      vpd_pkg::fp_type coef;
      vpd_pkg::fp_type vx;
      vpd_pkg::fp_type vy;
      vpd_pkg::fp_type vz;
   } req_item_type;

   typedef struct packed {
      vpd_pkg::fp_type px;
      vpd_pkg::fp_type py;
      vpd_pkg::fp_type pz;
      logic            wz;
   } proj_type;

   // one directed row: stimulus plus an optional typed-in expectation
   typedef struct packed {
      req_item_type item;
      logic         typed;
      proj_type     want;
   } dir_row_type;

   localparam int IdleLimit = 2000;   // cycles without any transfer
   localparam int DrainWait = 40;     // extra wait once no result is outstanding

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [135:0] req_tdata;   // [1:0] row, [3:2] col, [35:4] coef, [67:36] x,
                              // [99:68] y, [131:100] z, [135:132] zero
   logic         req_tuser;   // [0] mode
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;   // [31:0] proj_x, [63:32] proj_y, [95:64] proj_z
   logic         rsp_tuser;   // [0] w_zero

   vpd_pkg::fp_type coef_shadow [16];   // testbench copy of the matrix store
   proj_type        proj_q [$];         // projections still to come out
   dir_row_type     dir_rows [$];
   int              errors;
   int              idle_cycles;
   int              ready_stall;
   bit              burst;              // no idling on either side while set

   vertex_projection_divide DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // ---------------------------------------------------------------------
   // IEEE single arithmetic through double: the simulator's double ops are
   // exact IEEE, and rounding a double result of one single op back to
   // single gives the correctly rounded single result.
   // ---------------------------------------------------------------------
   function automatic real sp_to_real(vpd_pkg::fp_type b);
      logic [63:0] d;
      real         r;
      if (b[30:23] == 8'hFF) begin
         d = {b[31], 11'h7FF, b[22:0], 29'd0};
         r = $bitstoreal(d);
      end else if (b[30:23] == 8'd0) begin
         if (b[22:0] == 23'd0) begin
            r = $bitstoreal({b[31], 63'd0});
         end else begin
            // mantissa times 2^-149
            r = real'(b[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
            if (b[31]) r = -r;
         end
      end else begin
         d = {b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'd0};
         r = $bitstoreal(d);
      end
      return r;
   endfunction

   // round to nearest even, subnormals kept, any NaN to the canonical one
   function automatic vpd_pkg::fp_type real_to_sp(real r);
      logic [63:0]     d;
      logic [63:0]     sig;
      logic [63:0]     q;
      logic [63:0]     rem;
      logic [63:0]     half;
      logic [63:0]     packed_bits;
      int              ex;
      int              sh;
      vpd_pkg::fp_type res;
      d  = $realtobits(r);
      ex = int'(d[62:52]) - 1023;
      if (d[62:52] == 11'h7FF) begin
         res = (d[51:0] != 52'd0) ? vpd_pkg::CanonNan : {d[63], 8'hFF, 23'd0};
      end else if (d[62:52] == 11'd0 || ex < -160) begin
         res = {d[63], 31'd0};
      end else if (ex > 127) begin
         res = {d[63], 8'hFF, 23'd0};
      end else begin
         sig = {11'd0, 1'b1, d[51:0]};
         sh  = (ex >= -126) ? 29 : 29 + (-126 - ex);
         if (sh > 60) sh = 60;
         q    = sig >> sh;
         rem  = sig & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         if (rem > half || (rem == half && q[0])) q = q + 64'd1;
         // hidden bit carries into the exponent field on its own
         if (ex >= -126) packed_bits = (64'(ex + 126) << 23) + q;
         else            packed_bits = q;
         if (packed_bits >= 64'h7F80_0000) res = {d[63], 8'hFF, 23'd0};
         else                              res = {d[63], packed_bits[30:0]};
      end
      return res;
   endfunction

   function automatic vpd_pkg::fp_type sp_mul(vpd_pkg::fp_type a, vpd_pkg::fp_type b);
      return real_to_sp(sp_to_real(a) * sp_to_real(b));
   endfunction

   function automatic vpd_pkg::fp_type sp_add(vpd_pkg::fp_type a, vpd_pkg::fp_type b);
      return real_to_sp(sp_to_real(a) + sp_to_real(b));
   endfunction

   function automatic vpd_pkg::fp_type sp_div(vpd_pkg::fp_type a, vpd_pkg::fp_type b);
      return real_to_sp(sp_to_real(a) / sp_to_real(b));
   endfunction

   // row vector (x, y, z, 1) times the shadow matrix, then perspective divide
   function automatic proj_type project_vertex(vpd_pkg::fp_type vx, vpd_pkg::fp_type vy,
                                               vpd_pkg::fp_type vz);
      vpd_pkg::fp_type v [4];
      vpd_pkg::fp_type p [4];
      vpd_pkg::fp_type acc;
      proj_type        res;
      v[0] = vx;
      v[1] = vy;
      v[2] = vz;
      v[3] = 32'h3F80_0000;
      for (int j = 0; j < 4; j++) begin
         acc = vpd_pkg::PosZero;
         for (int i = 0; i < 4; i++) acc = sp_add(acc, sp_mul(v[i], coef_shadow[i*4+j]));
         p[j] = acc;
      end
      res.wz = (p[3][30:0] == 31'd0);
      if (!res.wz) begin
         // NaN w counts as nonzero
         for (int j = 0; j < 3; j++) p[j] = sp_div(p[j], p[3]);
      end
      res.px = vpd_pkg::canon(p[0]);
      res.py = vpd_pkg::canon(p[1]);
      res.pz = vpd_pkg::canon(p[2]);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   function automatic vpd_pkg::fp_type rand_fp();
      vpd_pkg::fp_type f;
      f = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: f[30:23] = 8'($urandom_range(117, 137));
         5:             ;                                  // raw bit pattern
         6:             f[30:0] = 31'd0;                   // signed zero
         7:             f[30:23] = 8'hFF;                  // inf or NaN
         8:             f[30:23] = 8'd0;                   // subnormal
         default:       f[30:23] = 8'($urandom_range(0, 1) ? $urandom_range(1, 40)
                                                           : $urandom_range(215, 254));
      endcase
      if ($urandom_range(0, 9) == 0) f[22:0] = 23'd0;      // exact powers of two
      return f;
   endfunction

   function automatic req_item_type rand_item(op_type mode);
      req_item_type it;
      it.mode = mode;
      it.row  = 2'($urandom_range(0, 3));
      it.col  = 2'($urandom_range(0, 3));
      it.coef = ($urandom_range(0, 3) == 0)
              ? vpd_pkg::fp_type'($urandom_range(0, 1) << 31) : rand_fp();
      it.vx   = rand_fp();
      it.vy   = rand_fp();
      it.vz   = rand_fp();
      return it;
   endfunction

   task automatic add_row(op_type mode, logic [1:0] row, logic [1:0] col,
                          vpd_pkg::fp_type coef, vpd_pkg::fp_type vx,
                          vpd_pkg::fp_type vy, vpd_pkg::fp_type vz, logic typed,
                          vpd_pkg::fp_type ex, vpd_pkg::fp_type ey,
                          vpd_pkg::fp_type ez, logic ewz);
      dir_row_type r;
      r.item  = '{mode, row, col, coef, vx, vy, vz};
      r.typed = typed;
      r.want  = '{ex, ey, ez, ewz};
      dir_rows.push_back(r);
   endtask

   // one transfer on req; the expectation is formed at the transfer edge
   task automatic send_item(req_item_type it, int gap, logic typed, proj_type want);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.mode;
      req_tdata  <= {4'd0, it.vz, it.vy, it.vx, it.coef, it.col, it.row};
      do @(posedge clock); while (!req_tready);
      if (it.mode == LOAD_COEF) begin
         coef_shadow[{it.row, it.col}] = it.coef;
      end else if (typed) begin
         proj_q.push_back(want);
      end else begin
         proj_q.push_back(project_vertex(it.vx, it.vy, it.vz));
      end
   endtask

   function automatic int draw_gap();
      return burst ? 0 : $urandom_range(0, 15);
   endfunction

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      proj_type     none;
      req_item_type it;
      int           n_rand;
      none       = '{vpd_pkg::PosZero, vpd_pkg::PosZero, vpd_pkg::PosZero, 1'b0};
      errors     = 0;
      burst      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = LOAD_COEF;
      foreach (coef_shadow[k]) coef_shadow[k] = vpd_pkg::PosZero;

      // fresh matrix is all +0: every coordinate +0, w zero
      add_row(XFORM_VERTEX, 2'd0, 2'd0, 32'h0, 32'h3F80_0000, 32'h4000_0000,
              32'h4040_0000, 1'b1, vpd_pkg::PosZero, vpd_pkg::PosZero,
              vpd_pkg::PosZero, 1'b1);
      // NaN input: NaN times zero poisons every column, NaN w still divides
      add_row(XFORM_VERTEX, 2'd3, 2'd3, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0,
              32'h0, 1'b1, vpd_pkg::CanonNan, vpd_pkg::CanonNan, vpd_pkg::CanonNan, 1'b0);
      add_row(XFORM_VERTEX, 2'd3, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 1'b1, vpd_pkg::CanonNan, vpd_pkg::CanonNan,
              vpd_pkg::CanonNan, 1'b0);
      // identity; vertex fields of a load are don't-care, the first load drives them all ones
      add_row(LOAD_COEF, 2'd0, 2'd0, 32'h3F80_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 1'b0, none.px, none.py, none.pz, 1'b0);
      add_row(LOAD_COEF, 2'd1, 2'd1, 32'h3F80_0000, 32'h0, 32'h0, 32'h0,
              1'b0, none.px, none.py, none.pz, 1'b0);
      add_row(LOAD_COEF, 2'd2, 2'd2, 32'h3F80_0000, 32'h0, 32'h0, 32'h0,
              1'b0, none.px, none.py, none.pz, 1'b0);
      add_row(LOAD_COEF, 2'd3, 2'd3, 32'h3F80_0000, 32'h0, 32'h0, 32'h0,
              1'b0, none.px, none.py, none.pz, 1'b0);
      add_row(XFORM_VERTEX, 2'd3, 2'd3, 32'hFFFF_FFFF, 32'h4000_0000, 32'h4080_0000,
              32'h4100_0000, 1'b1, 32'h4000_0000, 32'h4080_0000, 32'h4100_0000, 1'b0);
      // w forced to zero: coordinates pass undivided
      add_row(LOAD_COEF, 2'd3, 2'd3, vpd_pkg::PosZero, 32'h0, 32'h0, 32'h0,
              1'b0, none.px, none.py, none.pz, 1'b0);
      add_row(XFORM_VERTEX, 2'd0, 2'd0, 32'h0, 32'h4000_0000, 32'h4080_0000,
              32'h4100_0000, 1'b1, 32'h4000_0000, 32'h4080_0000, 32'h4100_0000, 1'b1);
      // w = z
      add_row(LOAD_COEF, 2'd2, 2'd3, 32'h3F80_0000, 32'h0, 32'h0, 32'h0,
              1'b0, none.px, none.py, none.pz, 1'b0);
      add_row(XFORM_VERTEX, 2'd0, 2'd0, 32'h0, 32'h4000_0000, 32'h4080_0000,
              32'h4100_0000, 1'b1, 32'h3E80_0000, 32'h3F00_0000, 32'h3F80_0000, 1'b0);
      // z = -0 gives w = +0: w zero flag, z sums to +0
      add_row(XFORM_VERTEX, 2'd0, 2'd0, 32'h0, 32'h4000_0000, 32'h4080_0000,
              vpd_pkg::NegZero, 1'b1, 32'h4000_0000, 32'h4080_0000,
              vpd_pkg::PosZero, 1'b1);
      // z = inf: inf times a zero coefficient poisons x and y, inf/inf in z
      add_row(XFORM_VERTEX, 2'd0, 2'd0, 32'h0, 32'h4000_0000, 32'h4080_0000,
              32'h7F80_0000, 1'b1, vpd_pkg::CanonNan, vpd_pkg::CanonNan,
              vpd_pkg::CanonNan, 1'b0);
      // subnormal and extreme magnitudes, checked by the predictor
      add_row(XFORM_VERTEX, 2'd1, 2'd2, 32'h0, 32'h0000_0001, 32'h807F_FFFF,
              32'h0000_0003, 1'b0, none.px, none.py, none.pz, 1'b0);
      add_row(LOAD_COEF, 2'd3, 2'd0, 32'h7F7F_FFFF, 32'h0, 32'h0, 32'h0,
              1'b0, none.px, none.py, none.pz, 1'b0);
      add_row(LOAD_COEF, 2'd0, 2'd1, 32'hFF7F_FFFF, 32'h0, 32'h0, 32'h0,
              1'b0, none.px, none.py, none.pz, 1'b0);
      add_row(XFORM_VERTEX, 2'd0, 2'd0, 32'h0, 32'h7F7F_FFFF, 32'h0080_0000,
              32'h3F80_0000, 1'b0, none.px, none.py, none.pz, 1'b0);
      add_row(LOAD_COEF, 2'd3, 2'd3, 32'h0000_0001, 32'h0, 32'h0, 32'h0,
              1'b0, none.px, none.py, none.pz, 1'b0);
      add_row(XFORM_VERTEX, 2'd0, 2'd0, 32'h0, 32'hC2F6_E979, 32'h3DCC_CCCD,
              32'h0000_0000, 1'b0, none.px, none.py, none.pz, 1'b0);
      add_row(LOAD_COEF, 2'd3, 2'd3, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
              1'b0, none.px, none.py, none.pz, 1'b0);
      add_row(XFORM_VERTEX, 2'd3, 2'd3, 32'hFFFF_FFFF, 32'h3F80_0000, 32'h3F80_0000,
              32'h3F80_0000, 1'b0, none.px, none.py, none.pz, 1'b0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k])
         send_item(dir_rows[k].item, draw_gap(), dir_rows[k].typed, dir_rows[k].want);

      // random part: a third loads, the rest vertices; burst mode is redrawn every 60 items
      n_rand = 450;
      for (int k = 0; k < n_rand; k++) begin
         if (k % 60 == 0) burst = ($urandom_range(0, 2) == 0);
         it = rand_item(($urandom_range(0, 2) == 0) ? LOAD_COEF : XFORM_VERTEX);
         send_item(it, draw_gap(), 1'b0, none);
      end
      req_tvalid <= 1'b0;

      while (proj_q.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      if (errors == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // rsp side: random backpressure per transfer, compare with oldest entry
   // ---------------------------------------------------------------------
   initial rsp_tready = 1'b0;

   always @(posedge clock) begin
      proj_type got;
      proj_type want;
      logic     nxt_ready;
      nxt_ready = rsp_tready;
      if (reset) begin
         ready_stall = 0;
         nxt_ready   = 1'b1;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser};
            if (proj_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result transfer: %h %b",
                                          rsp_tdata, rsp_tuser);
            end else begin
               want = proj_q.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp x=%h y=%h z=%h wz=%b got x=%h y=%h z=%h wz=%b",
                              want.px, want.py, want.pz, want.wz,
                              got.px, got.py, got.pz, got.wz);
               end
            end
            ready_stall = burst ? 0 : $urandom_range(0, 15);
         end else if (ready_stall > 0) begin
            ready_stall--;
         end
         nxt_ready = (ready_stall == 0);
      end
      rsp_tready <= nxt_ready;
   end

   // watchdog: too long with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
